// ----- hdl/multi_pattern_string_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern string matcher
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_STRING_MATCHER_MACROS_SVH
`define MULTI_PATTERN_STRING_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define MPSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mpsm assertion failed");
// When the first expression holds, the second must hold in the next cycle.
`define MPSM_ASSERT_NEXT(lbl, clk, rst, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error("mpsm assertion failed");
`else
`define MPSM_ASSERT(lbl, clk, rst, prop)
`define MPSM_ASSERT_NEXT(lbl, clk, rst, cond, res)
`endif
`endif

// ----- hdl/mpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mpsm_pkg
// Sizes, table entry types and codes shared by the string matcher modules.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int MAX_STATES    = 512;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_KEYWORDS  = 32;

  localparam int NODE_W     = $clog2(MAX_STATES);
  localparam int CNT_W      = $clog2(MAX_STATES + 1);
  localparam int SYM_W      = $clog2(ALPHABET_SIZE);
  localparam int KW_W       = $clog2(MAX_KEYWORDS + 1);
  localparam int GOTO_DEPTH = MAX_STATES * ALPHABET_SIZE;
  localparam int GA_W       = $clog2(GOTO_DEPTH);

  // Port field widths.
  localparam int OP_W     = 3;
  localparam int SYMBOL_W = 8;
  localparam int STATUS_W = 3;
  localparam int SCAN_W   = 9;
  localparam int MASK_W   = 32;
  localparam int POS_W    = 32;
  localparam int USED_W   = 10;
  localparam int LOADED_W = 6;

  typedef logic [NODE_W-1:0]       node_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [SYM_W-1:0]        sym_t;
  typedef logic [KW_W-1:0]         kw_t;
  typedef logic [MAX_KEYWORDS-1:0] kmask_t;
  typedef logic [GA_W-1:0]         gaddr_t;

  typedef struct packed {
    logic  valid;
    node_t next;
  } goto_ent_t;

  typedef struct packed {
    node_t  fail;
    kmask_t mask;
  } node_ent_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_KEY   = 3'd1,
    OP_END   = 3'd2,
    OP_BUILD = 3'd3,
    OP_TEXT  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_KEYWORDS  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_t;

  typedef struct packed {
    op_t  op;
    logic sym_ok;
    sym_t sym_idx;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [SCAN_W-1:0]   scan_state;
    logic [MASK_W-1:0]   match_mask;
    logic [POS_W-1:0]    text_position;
    logic [USED_W-1:0]   states_used;
    logic [LOADED_W-1:0] keywords_loaded;
  } result_t;

  function automatic gaddr_t goto_addr(input node_t n, input sym_t c);
    return gaddr_t'(n) * gaddr_t'(ALPHABET_SIZE) + gaddr_t'(c);
  endfunction

endpackage

// ----- hdl/mpsm_symmap.sv -----
// ----------------------------------------------------------------------------
// mpsm_symmap
// Maps a raw byte onto an alphabet index and checks that it is in range.
// ----------------------------------------------------------------------------
module mpsm_symmap (
  input  logic [mpsm_pkg::SYMBOL_W-1:0] symbol,
  input  logic [mpsm_pkg::SYMBOL_W-1:0] lowest,
  input  logic [mpsm_pkg::SYMBOL_W-1:0] highest,
  output logic                          sym_ok,
  output mpsm_pkg::sym_t                sym_idx
);
  import mpsm_pkg::*;

  logic [SYMBOL_W-1:0] diff;

  assign diff    = symbol - lowest;
  assign sym_ok  = (symbol >= lowest) && (symbol <= highest) &&
                   ({1'b0, diff} < (SYMBOL_W + 1)'(ALPHABET_SIZE));
  assign sym_idx = sym_t'(diff);

endmodule

// ----- hdl/mpsm_engine.sv -----
// ----------------------------------------------------------------------------
// mpsm_engine
// Trie, failure links and masks in block memories, driven by a sequencer.
// ----------------------------------------------------------------------------
`include "multi_pattern_string_matcher_macros.svh"

module mpsm_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mpsm_pkg::item_t   item,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output mpsm_pkg::result_t res
);
  import mpsm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_INS_RD, S_INS, S_END_RD, S_END, S_B0_RD, S_B0,
    S_R_RD, S_R, S_R_N, S_Q, S_Q_D, S_S, S_E_RD, S_E, S_F_RD, S_F, S_F_N,
    S_M, S_C, S_T_RD, S_T, S_T_N, S_T_M, S_PUT
  } state_t;

  state_t state;

  // Memories.
  goto_ent_t goto_mem [GOTO_DEPTH];
  node_ent_t node_mem [MAX_STATES];
  node_t     queue_mem [MAX_STATES];

  logic      goto_we, node_we, queue_we;
  gaddr_t    goto_wa, goto_ra;
  goto_ent_t goto_wd, goto_rd;
  node_t     node_wa, node_ra;
  node_ent_t node_wd, node_rd;
  node_t     queue_wa, queue_ra, queue_wd, queue_rd;

  // Control and working registers.
  gaddr_t  clr_addr;
  logic    clr_reply;
  cnt_t    node_count;
  kw_t     kw_count;
  node_t   cursor;
  node_t   scan;
  logic [POS_W-1:0] pos;
  logic    built;
  cnt_t    head, tail;
  cnt_t    guard;
  sym_t    cc;
  node_t   walk, child, src, fail_s;
  kmask_t  m0, mf;
  status_t status_r;
  kmask_t  mask_out;
  logic [POS_W-1:0] pos_out;

  logic  last_sym;
  logic  walk_more;
  node_t walk_dst;

  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    goto_rd <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd <= queue_mem[queue_ra];
  end

  assign last_sym  = (cc == sym_t'(ALPHABET_SIZE - 1));
  // A missing edge keeps the walk on failure links until the guard runs out.
  assign walk_more = !goto_rd.valid && (guard < cnt_t'(MAX_STATES));
  assign walk_dst  = goto_rd.valid ? goto_rd.next : node_t'(0);

  always_comb begin
    goto_we  = 1'b0;
    goto_wa  = goto_addr(cursor, cc);
    goto_wd  = '0;
    goto_ra  = goto_addr(walk, cc);
    node_we  = 1'b0;
    node_wa  = child;
    node_wd  = '0;
    node_ra  = child;
    queue_we = 1'b0;
    queue_wa = tail[NODE_W-1:0];
    queue_wd = child;
    queue_ra = head[NODE_W-1:0];
    case (state)
      S_CLEAR: begin
        goto_we = 1'b1;
        goto_wa = clr_addr;
        node_we = (clr_addr < gaddr_t'(MAX_STATES));
        node_wa = node_t'(clr_addr);
      end
      S_INS_RD: goto_ra = goto_addr(cursor, cc);
      S_INS: begin
        goto_we = !(goto_rd.valid && !(cursor == '0 && goto_rd.next == '0)) &&
                  (node_count < cnt_t'(MAX_STATES));
        goto_wd = '{valid: 1'b1, next: node_t'(node_count)};
      end
      S_END_RD: node_ra = cursor;
      S_END: begin
        node_we = 1'b1;
        node_wa = cursor;
        node_wd = '{fail: node_rd.fail, mask: node_rd.mask | (kmask_t'(1) << kw_count)};
      end
      S_B0_RD: node_ra = '0;
      S_R_RD:  goto_ra = gaddr_t'(cc);
      S_R: begin
        goto_we = !goto_rd.valid;
        goto_wa = gaddr_t'(cc);
        goto_wd = '{valid: 1'b1, next: node_t'(0)};
        node_ra = goto_rd.next;
      end
      S_R_N: begin
        node_we  = 1'b1;
        node_wd  = '{fail: node_t'(0), mask: node_rd.mask | m0};
        queue_we = 1'b1;
      end
      S_Q_D:  node_ra = queue_rd;
      S_E_RD: goto_ra = goto_addr(src, cc);
      S_F_RD, S_T_RD: goto_ra = goto_addr(walk, cc);
      S_F, S_T: node_ra = walk_more ? walk : walk_dst;
      S_M: node_ra = child;
      S_C: begin
        node_we  = 1'b1;
        node_wd  = '{fail: walk, mask: node_rd.mask | mf};
        queue_we = (tail < cnt_t'(MAX_STATES));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      node_count <= cnt_t'(1);
      kw_count   <= '0;
      cursor     <= '0;
      scan       <= '0;
      pos        <= '0;
      built      <= 1'b0;
      head       <= '0;
      tail       <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == gaddr_t'(GOTO_DEPTH - 1)) begin
            state <= clr_reply ? S_PUT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + gaddr_t'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            status_r <= ST_OK;
            mask_out <= '0;
            pos_out  <= '0;
            cc       <= item.sym_idx;
            case (item.op)
              OP_CLEAR: begin
                node_count <= cnt_t'(1);
                kw_count   <= '0;
                cursor     <= '0;
                scan       <= '0;
                pos        <= '0;
                built      <= 1'b0;
                clr_addr   <= '0;
                clr_reply  <= 1'b1;
                state      <= S_CLEAR;
              end
              OP_KEY: begin
                if (kw_count >= kw_t'(MAX_KEYWORDS)) begin
                  status_r <= ST_KEYWORDS;
                  state    <= S_PUT;
                end else if (!item.sym_ok) begin
                  status_r <= ST_RANGE;
                  state    <= S_PUT;
                end else begin
                  state <= S_INS_RD;
                end
              end
              OP_END: begin
                if (kw_count >= kw_t'(MAX_KEYWORDS)) begin
                  status_r <= ST_KEYWORDS;
                  state    <= S_PUT;
                end else begin
                  state <= S_END_RD;
                end
              end
              OP_BUILD: begin
                head  <= '0;
                tail  <= '0;
                state <= S_B0_RD;
              end
              OP_TEXT: begin
                if (!built) begin
                  status_r <= ST_NOT_BUILT;
                  state    <= S_PUT;
                end else if (!item.sym_ok) begin
                  status_r <= ST_RANGE;
                  state    <= S_PUT;
                end else begin
                  walk  <= scan;
                  guard <= '0;
                  state <= S_T_RD;
                end
              end
              default: state <= S_PUT;
            endcase
          end
        end
        S_INS_RD: state <= S_INS;
        S_INS: begin
          built <= 1'b0;
          if (goto_rd.valid && !(cursor == '0 && goto_rd.next == '0)) begin
            cursor <= goto_rd.next;
          end else if (node_count >= cnt_t'(MAX_STATES)) begin
            status_r <= ST_FULL;
          end else begin
            cursor     <= node_t'(node_count);
            node_count <= node_count + cnt_t'(1);
          end
          state <= S_PUT;
        end
        S_END_RD: state <= S_END;
        S_END: begin
          kw_count <= kw_count + kw_t'(1);
          cursor   <= '0;
          built    <= 1'b0;
          state    <= S_PUT;
        end
        S_B0_RD: state <= S_B0;
        S_B0: begin
          m0    <= node_rd.mask;
          cc    <= '0;
          state <= S_R_RD;
        end
        S_R_RD: state <= S_R;
        S_R: begin
          child <= goto_rd.next;
          if (goto_rd.valid && goto_rd.next != '0 && tail < cnt_t'(MAX_STATES)) begin
            state <= S_R_N;
          end else if (last_sym) begin
            state <= S_Q;
          end else begin
            cc    <= cc + sym_t'(1);
            state <= S_R_RD;
          end
        end
        S_R_N: begin
          tail <= tail + cnt_t'(1);
          if (last_sym) begin
            state <= S_Q;
          end else begin
            cc    <= cc + sym_t'(1);
            state <= S_R_RD;
          end
        end
        S_Q: begin
          if (head < tail) begin
            state <= S_Q_D;
          end else begin
            scan  <= '0;
            pos   <= '0;
            built <= 1'b1;
            state <= S_PUT;
          end
        end
        S_Q_D: begin
          src   <= queue_rd;
          head  <= head + cnt_t'(1);
          state <= S_S;
        end
        S_S: begin
          fail_s <= node_rd.fail;
          cc     <= '0;
          state  <= S_E_RD;
        end
        S_E_RD: state <= S_E;
        S_E: begin
          if (goto_rd.valid) begin
            child <= goto_rd.next;
            walk  <= fail_s;
            guard <= '0;
            state <= S_F_RD;
          end else if (last_sym) begin
            state <= S_Q;
          end else begin
            cc    <= cc + sym_t'(1);
            state <= S_E_RD;
          end
        end
        S_F_RD: state <= S_F;
        S_F: begin
          if (walk_more) begin
            state <= S_F_N;
          end else begin
            walk  <= walk_dst;
            state <= S_M;
          end
        end
        S_F_N: begin
          walk  <= node_rd.fail;
          guard <= guard + cnt_t'(1);
          state <= S_F_RD;
        end
        S_M: begin
          mf    <= node_rd.mask;
          state <= S_C;
        end
        S_C: begin
          if (tail < cnt_t'(MAX_STATES)) tail <= tail + cnt_t'(1);
          if (last_sym) begin
            state <= S_Q;
          end else begin
            cc    <= cc + sym_t'(1);
            state <= S_E_RD;
          end
        end
        S_T_RD: state <= S_T;
        S_T: begin
          if (walk_more) begin
            state <= S_T_N;
          end else begin
            scan  <= walk_dst;
            state <= S_T_M;
          end
        end
        S_T_N: begin
          walk  <= node_rd.fail;
          guard <= guard + cnt_t'(1);
          state <= S_T_RD;
        end
        S_T_M: begin
          mask_out <= node_rd.mask;
          pos_out  <= pos;
          pos      <= pos + POS_W'(1);
          state    <= S_PUT;
        end
        S_PUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_PUT);

  always_comb begin
    res.status          = status_r;
    res.scan_state      = SCAN_W'(scan);
    res.match_mask      = MASK_W'(mask_out);
    res.text_position   = pos_out;
    res.states_used     = USED_W'(node_count);
    res.keywords_loaded = LOADED_W'(kw_count);
  end

  `MPSM_ASSERT(a_node_range, clk, rst, (node_count >= cnt_t'(1)) && (node_count <= cnt_t'(MAX_STATES)))
  `MPSM_ASSERT(a_kw_range, clk, rst, kw_count <= kw_t'(MAX_KEYWORDS))
  `MPSM_ASSERT(a_queue_order, clk, rst, head <= tail)
  `MPSM_ASSERT_NEXT(a_start_leaves_idle, clk, rst, start && (state == S_IDLE), state != S_IDLE)

endmodule

// ----- hdl/multi_pattern_string_matcher.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Dictionary matcher: keyword trie, failure-link build and text scanning.
// ----------------------------------------------------------------------------
// Usage. Each input word on the s_ channel carries an op and a symbol. Op 0
// clears the dictionary, op 1 appends a keyword symbol, op 2 closes the
// keyword, op 3 builds the failure links and op 4 scans one text symbol.
// Every input word yields exactly one output word on the m_ channel with a
// status code, the scan state, the match mask, the text position and the
// trie and keyword counts. The cfg channel writes the alphabet bounds
// (index 0 lowest symbol, index 1 highest symbol) and is always ready.
// Throughput: one word at a time. Ops 1 and 2 and each text symbol wait on
// the registered reads of the goto and node memories; a text symbol also
// follows failure links where an edge is missing. A build walks the trie
// breadth first, visiting every alphabet entry of the root and of each
// node taken from the queue and following failure links for each child
// edge; op 0 sweeps the goto memory.
// Reset runs the same clearing pass; s_tready stays low until it ends. A
// finished result sits in the output register, so the next word is taken
// while the receiver stalls; the engine then waits to hand over.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher (
  input  logic        clk,
  input  logic        rst,
  // Input words. s_tdata: op [2:0], symbol [10:3], zero fill above.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Result words. m_tdata: status [2:0], scan_state [11:3],
  // match_mask [43:12], text_position [75:44], states_used [85:76],
  // keywords_loaded [91:86], zero fill above.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mpsm_pkg::*;

  localparam logic [7:0] REG_LOWEST  = 8'd0;
  localparam logic [7:0] REG_HIGHEST = 8'd1;

  logic [SYMBOL_W-1:0] lowest_symbol;
  logic [SYMBOL_W-1:0] highest_symbol;

  item_t   item;
  logic    start;
  logic    idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // The register bank never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_symbol  <= 8'd97;
      highest_symbol <= 8'd122;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOWEST:  lowest_symbol  <= cfg_data;
        REG_HIGHEST: highest_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  mpsm_symmap u_symmap (
    .symbol  (s_tdata[10:3]),
    .lowest  (lowest_symbol),
    .highest (highest_symbol),
    .sym_ok  (item.sym_ok),
    .sym_idx (item.sym_idx)
  );

  assign item.op  = op_t'(s_tdata[2:0]);
  assign s_tready = idle;
  assign start    = s_tvalid && s_tready;

  mpsm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: the engine hands over when it is empty or draining.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0, res.keywords_loaded, res.states_used, res.text_position,
                  res.match_mask, res.scan_state, res.status};
    end
  end

endmodule
